### design/rnes_pkg.sv
// Shared types and constants for the radix number-entry stack.
`timescale 1ns / 1ps

package rnes_pkg;

   localparam int MODE_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int RADIX_W     = 2;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_OUT_W = 5;
   localparam int FRAC_W      = 64;
   localparam int QUOT_W      = 32;
   localparam int VALUE_W     = 64;
   localparam int DIGIT_CNT_W = 4;
   localparam int FLAGS_W     = 2;

   localparam logic [MODE_W-1:0] MODE_CHAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DUP  = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
   localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd1;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd2;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_F     = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

   localparam int FLAG_INVALID   = 0;
   localparam int FLAG_SATURATED = 1;

   typedef struct packed {
      logic take;
      logic clear;
   } entry_ctrl_type;

endpackage

### design/rnes_entry.sv
// Character decode and integer/fraction accumulation for one number entry.
`timescale 1ns / 1ps

module rnes_entry #(
   parameter int INT_BITS    = 32,
   parameter int FRAC_DIGITS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rnes_pkg::entry_ctrl_type            ctrl,
   input  logic [rnes_pkg::CHAR_W-1:0]         char_code,
   input  logic [rnes_pkg::RADIX_W-1:0]        radix_select,
   output logic [INT_BITS-1:0]                 integer_accum,
   output logic [rnes_pkg::FRAC_W-1:0]         frac_numerator,
   output logic [rnes_pkg::FRAC_W-1:0]         frac_denominator,
   output logic [rnes_pkg::FLAGS_W-1:0]        entry_flags
);

   localparam logic [rnes_pkg::FRAC_W-1:0] INT_LIMIT =
      (rnes_pkg::FRAC_W'(1) << INT_BITS) - rnes_pkg::FRAC_W'(1);
   localparam logic [rnes_pkg::DIGIT_CNT_W-1:0] MAX_DIGITS =
      rnes_pkg::DIGIT_CNT_W'(FRAC_DIGITS);

   logic [INT_BITS-1:0]                 accum_ff, accum_in;
   logic [rnes_pkg::FRAC_W-1:0]         num_ff, num_in;
   logic [rnes_pkg::FRAC_W-1:0]         den_ff, den_in;
   logic [rnes_pkg::DIGIT_CNT_W-1:0]    count_ff, count_in;
   logic                                seen_ff, seen_in;
   logic [rnes_pkg::FLAGS_W-1:0]        flags_ff, flags_in;

   logic                                is_point, is_dec, is_hex, valid_digit, bad;
   logic [3:0]                          digit, digit_use;
   logic [4:0]                          radix;
   logic [rnes_pkg::FRAC_W-1:0]         int_sum;
   logic                                sat;

   function automatic logic [4:0] radix_value(input logic [rnes_pkg::RADIX_W-1:0] sel);
      logic [4:0] r;
      unique case (sel)
         rnes_pkg::RADIX_DEC: r = 5'd10;
         rnes_pkg::RADIX_BIN: r = 5'd2;
         rnes_pkg::RADIX_OCT: r = 5'd8;
         default:             r = 5'd16;
      endcase
      return r;
   endfunction

   function automatic logic [rnes_pkg::FRAC_W-1:0] scale(
      input logic [rnes_pkg::FRAC_W-1:0] x,
      input logic [rnes_pkg::RADIX_W-1:0] sel
   );
      logic [rnes_pkg::FRAC_W-1:0] y;
      unique case (sel)
         rnes_pkg::RADIX_DEC: y = (x << 3) + (x << 1);
         rnes_pkg::RADIX_BIN: y = x << 1;
         rnes_pkg::RADIX_OCT: y = x << 3;
         default:             y = x << 4;
      endcase
      return y;
   endfunction

   always_comb begin
      is_point = (char_code == rnes_pkg::CHAR_POINT);
      is_dec   = (char_code >= rnes_pkg::CHAR_ZERO) && (char_code <= rnes_pkg::CHAR_NINE);
      is_hex   = (char_code >= rnes_pkg::CHAR_A) && (char_code <= rnes_pkg::CHAR_F);
      radix    = radix_value(radix_select);
      if (is_dec) begin
         digit = 4'(char_code - rnes_pkg::CHAR_ZERO);
      end else if (is_hex) begin
         digit = 4'(char_code - rnes_pkg::CHAR_A + 8'd10);
      end else begin
         digit = 4'd0;
      end
      valid_digit = (is_dec || is_hex) && ({1'b0, digit} < radix);
      digit_use   = valid_digit ? digit : 4'd0;
      bad         = !valid_digit;
      int_sum     = scale(rnes_pkg::FRAC_W'(accum_ff), radix_select)
                    + rnes_pkg::FRAC_W'(digit_use);
      sat         = (int_sum > INT_LIMIT);

      accum_in = accum_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      flags_in = flags_ff;
      if (ctrl.clear) begin
         accum_in = '0;
         num_in   = '0;
         den_in   = rnes_pkg::FRAC_W'(1);
         count_in = '0;
         seen_in  = 1'b0;
         flags_in = '0;
      end else if (ctrl.take) begin
         if (is_point && !seen_ff) begin
            seen_in = 1'b1;
         end else begin
            if (bad) begin
               flags_in[rnes_pkg::FLAG_INVALID] = 1'b1;
            end
            if (!seen_ff) begin
               if (sat) begin
                  accum_in = '1;
                  flags_in[rnes_pkg::FLAG_SATURATED] = 1'b1;
               end else begin
                  accum_in = int_sum[INT_BITS-1:0];
               end
            end else if (count_ff < MAX_DIGITS) begin
               num_in   = scale(num_ff, radix_select) + rnes_pkg::FRAC_W'(digit_use);
               den_in   = scale(den_ff, radix_select);
               count_in = count_ff + rnes_pkg::DIGIT_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         num_ff   <= '0;
         den_ff   <= rnes_pkg::FRAC_W'(1);
         count_ff <= '0;
         seen_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         accum_ff <= accum_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
         flags_ff <= flags_in;
      end
   end

   assign integer_accum    = accum_ff;
   assign frac_numerator   = num_ff;
   assign frac_denominator = den_ff;
   assign entry_flags      = flags_ff;

endmodule

### design/rnes_frac_div.sv
// Bit-serial restoring divider forming the 32-bit fraction of an entry.
`timescale 1ns / 1ps

module rnes_frac_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rnes_pkg::FRAC_W-1:0]       numerator,
   input  logic [rnes_pkg::FRAC_W-1:0]       denominator,
   output logic [rnes_pkg::QUOT_W-1:0]       quotient,
   output logic                              done
);

   localparam int CNT_W = $clog2(rnes_pkg::QUOT_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(rnes_pkg::QUOT_W - 1);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [rnes_pkg::FRAC_W-1:0]    rem_ff, rem_in;
   logic [rnes_pkg::FRAC_W-1:0]    den_ff, den_in;
   logic [rnes_pkg::QUOT_W-1:0]    q_ff, q_in;
   logic [rnes_pkg::FRAC_W-1:0]    rem_shl;

   always_comb begin
      rem_shl = rem_ff << 1;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = numerator;
         den_in  = (denominator == '0) ? rnes_pkg::FRAC_W'(1) : denominator;
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_shl >= den_ff) begin
            rem_in = rem_shl - den_ff;
            q_in   = {q_ff[rnes_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shl;
            q_in   = {q_ff[rnes_pkg::QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

### design/radix_number_entry_stack.sv
// Top level: request sequencing, value stack memory and response register.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | req_mode, req_char_code, req_last
//  rsp     | out       | rsp_valid/rsp_ready | rsp_top_value, rsp_depth, rsp_status
//  csr     | in        | csr_valid/csr_ready | csr_radix_select
//
// Entry character without last: execute, then back to idle. Pop, duplicate: through
// the stack memory's registered read. Final character: start, wait on the 32-step
// fraction divider, push, then read. Synchronous reset; no clearing pass, the
// stack is read only below its depth. A request is taken while a response still
// waits; the sequencer holds in its last state until the response register frees.
`timescale 1ns / 1ps

module radix_number_entry_stack #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_DIGITS = 15,
   parameter int INT_BITS    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rnes_pkg::MODE_W-1:0]           req_mode,
   input  logic [rnes_pkg::CHAR_W-1:0]           req_char_code,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rnes_pkg::VALUE_W-1:0]          rsp_top_value,
   output logic [rnes_pkg::DEPTH_OUT_W-1:0]      rsp_depth,
   output logic [rnes_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rnes_pkg::RADIX_W-1:0]          csr_radix_select
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;
   localparam logic [2:0] S_COPY  = 3'd5;
   localparam logic [2:0] S_READ  = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   logic [2:0]                          state_ff, state_in;
   logic [DW-1:0]                       depth_ff, depth_in;
   logic [rnes_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [rnes_pkg::RADIX_W-1:0]        radix_ff;
   logic [rnes_pkg::MODE_W-1:0]         mode_ff;
   logic [rnes_pkg::CHAR_W-1:0]         char_ff;
   logic                                last_ff;

   logic                                rsp_valid_ff;
   logic [rnes_pkg::VALUE_W-1:0]        rsp_top_ff;
   logic [rnes_pkg::DEPTH_OUT_W-1:0]    rsp_depth_ff;
   logic [rnes_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic                                rsp_load;

   logic [rnes_pkg::VALUE_W-1:0]        mem [STACK_DEPTH];
   logic                                mem_we, rd_en;
   logic [AW-1:0]                       wr_addr, rd_addr;
   logic [rnes_pkg::VALUE_W-1:0]        wr_data, rd_data_ff;

   rnes_pkg::entry_ctrl_type            entry_ctrl;
   logic [INT_BITS-1:0]                 integer_accum;
   logic [rnes_pkg::FRAC_W-1:0]         frac_numerator, frac_denominator;
   logic [rnes_pkg::FLAGS_W-1:0]        entry_flags;
   logic                                div_start, div_done;
   logic [rnes_pkg::QUOT_W-1:0]         quotient;

   logic                                empty, full, accept;
   logic [DW-1:0]                       depth_m1;

   rnes_entry #(
      .INT_BITS    (INT_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_entry (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (entry_ctrl),
      .char_code        (char_ff),
      .radix_select     (radix_ff),
      .integer_accum    (integer_accum),
      .frac_numerator   (frac_numerator),
      .frac_denominator (frac_denominator),
      .entry_flags      (entry_flags)
   );

   rnes_frac_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (frac_numerator),
      .denominator (frac_denominator),
      .quotient    (quotient),
      .done        (div_done)
   );

   assign empty     = (depth_ff == '0);
   assign full      = (depth_ff >= FULL_DEPTH);
   assign depth_m1  = depth_ff - DW'(1);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in   = state_ff;
      depth_in   = depth_ff;
      status_in  = status_ff;
      entry_ctrl = '0;
      div_start  = 1'b0;
      mem_we     = 1'b0;
      wr_addr    = depth_ff[AW-1:0];
      wr_data    = rd_data_ff;
      rd_en      = 1'b0;
      rd_addr    = depth_m1[AW-1:0];
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = rnes_pkg::STATUS_OK;
            unique case (mode_ff)
               rnes_pkg::MODE_CHAR: begin
                  entry_ctrl.take = 1'b1;
                  state_in = last_ff ? S_START : S_IDLE;
               end
               rnes_pkg::MODE_POP: begin
                  if (empty) begin
                     status_in = rnes_pkg::STATUS_EMPTY;
                  end else begin
                     depth_in = depth_m1;
                  end
                  state_in = S_READ;
               end
               rnes_pkg::MODE_DUP: begin
                  if (empty) begin
                     status_in = rnes_pkg::STATUS_EMPTY;
                     state_in  = S_READ;
                  end else if (full) begin
                     status_in = rnes_pkg::STATUS_FULL;
                     state_in  = S_READ;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_COPY;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (full) begin
               status_in = rnes_pkg::STATUS_FULL;
            end else begin
               mem_we   = 1'b1;
               wr_data  = {rnes_pkg::QUOT_W'(integer_accum), quotient};
               depth_in = depth_ff + DW'(1);
               if (entry_flags[rnes_pkg::FLAG_INVALID]) begin
                  status_in = rnes_pkg::STATUS_INVALID;
               end else if (entry_flags[rnes_pkg::FLAG_SATURATED]) begin
                  status_in = rnes_pkg::STATUS_SATURATED;
               end
            end
            entry_ctrl.clear = 1'b1;
            state_in = S_READ;
         end
         S_COPY: begin
            mem_we   = 1'b1;
            depth_in = depth_ff + DW'(1);
            state_in = S_READ;
         end
         S_READ: begin
            rd_en    = !empty;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         radix_ff     <= rnes_pkg::RADIX_DEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         if (csr_valid && csr_ready) begin
            radix_ff <= csr_radix_select;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (accept) begin
         mode_ff <= req_mode;
         char_ff <= req_char_code;
         last_ff <= req_last;
      end
      if (rsp_load) begin
         rsp_top_ff    <= empty ? '0 : rd_data_ff;
         rsp_depth_ff  <= rnes_pkg::DEPTH_OUT_W'(depth_ff);
         rsp_status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
